[rtl/core/lgge_pkg.sv]
// Shared types and constants for the life grid generation engine.
// No dependencies; every other file in rtl/core but lgge_rsp_if refers to this package.
package lgge_pkg;

	localparam int GRID_SIZE_DEFAULT = 16;

	localparam int CMD_W   = 2;
	localparam int INDEX_W = 4;
	localparam int COUNT_W = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE   = 2'd0,
		CMD_READ    = 2'd1,
		CMD_ADVANCE = 2'd2,
		CMD_UNUSED  = 2'd3
	} command_t;

	localparam logic [COUNT_W-1:0] BIRTH_COUNT = 4'd3;
	localparam logic [COUNT_W-1:0] SURVIVE_LOW = 4'd2;

	// Control that the sequencer hands to every row cell.
	typedef struct packed {
		logic shift;
		logic wr;
		logic wr_val;
	} cell_ctrl_t;

endpackage

[rtl/core/lgge_cmd_if.sv]
// Request channel of the life grid generation engine: valid/ready plus command payload.
// Depends on lgge_pkg for field widths.
interface lgge_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [lgge_pkg::CMD_W-1:0]    command;
	logic [lgge_pkg::INDEX_W-1:0]  row;
	logic [lgge_pkg::INDEX_W-1:0]  column;
	logic                          cell_value;

	modport source (output valid, command, row, column, cell_value, input ready);
	modport sink   (input valid, command, row, column, cell_value, output ready);
endinterface

[rtl/core/lgge_rsp_if.sv]
// Response channel of the life grid generation engine: valid/ready plus read data.
// No package dependencies.
interface lgge_rsp_if;
	logic valid;
	logic ready;
	logic read_value;

	modport source (output valid, read_value, input ready);
	modport sink   (input valid, read_value, output ready);
endinterface

[rtl/core/life_grid_generation_engine.sv]
// Life grid generation engine: a GRID_SIZE x GRID_SIZE grid of one-bit cells under B3/S23.
//
// Channel cmd takes requests: write a cell, read a cell, or advance one generation.
// Channel rsp returns one read_value for every read request, in request order.
// A read result is registered and shows on rsp the cycle after the request is accepted.
// An advance holds cmd.ready low while its sweep runs: the rows form a chain of row
// cells that shifts one row per cycle past a single row update unit, so the sweep
// length is set by the number of rows.
// Out-of-range indexes: a write is dropped and a
// read returns 0. Command 3 is accepted and dropped.
// Reset (arst_n low) clears every cell to dead and empties the response register.
// When rsp stalls, the held result stays in its register; a new request is still
// taken in the cycle the receiver takes the held result, otherwise cmd.ready drops.
// Depends on lgge_pkg, lgge_cmd_if, lgge_rsp_if, lgge_row_cell and lgge_rule.
module life_grid_generation_engine #(
	parameter int GRID_SIZE = lgge_pkg::GRID_SIZE_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	lgge_cmd_if.sink  cmd,
	lgge_rsp_if.source rsp
);

	localparam int IW = $clog2(GRID_SIZE);

	logic [GRID_SIZE-1:0] rows [GRID_SIZE];
	logic [GRID_SIZE-1:0] new_row;
	logic [GRID_SIZE-1:0] below_row;
	logic [GRID_SIZE-1:0] prev_q;
	logic [GRID_SIZE-1:0] col_sel;
	logic [IW-1:0]        step_q;
	logic [IW-1:0]        ridx, cidx;
	logic                 busy_q, last_step, in_grid, accept;
	logic                 rsp_valid_q, rsp_data_q;
	lgge_pkg::cell_ctrl_t ctrl;

	assign in_grid  = (int'(cmd.row) < GRID_SIZE) && (int'(cmd.column) < GRID_SIZE);
	assign ridx     = IW'(cmd.row);
	assign cidx     = IW'(cmd.column);
	assign cmd.ready = !busy_q && (!rsp_valid_q || rsp.ready);
	assign accept   = cmd.valid && cmd.ready;
	assign last_step = (step_q == IW'(GRID_SIZE - 1));

	always_comb begin
		for (int j = 0; j < GRID_SIZE; j++) begin
			col_sel[j] = (cidx == IW'(j));
		end
	end

	assign ctrl.shift  = busy_q;
	assign ctrl.wr     = accept && in_grid && (cmd.command == lgge_pkg::CMD_WRITE);
	assign ctrl.wr_val = cmd.cell_value;

	// The head row is the one being updated; the row below it is dead past the bottom edge.
	assign below_row = last_step ? '0 : rows[1];

	lgge_rule #(.WIDTH(GRID_SIZE)) u_rule (
		.above (prev_q),
		.mid   (rows[0]),
		.below (below_row),
		.next  (new_row)
	);

	for (genvar i = 0; i < GRID_SIZE; i++) begin : g_row
		logic [GRID_SIZE-1:0] shift_in;
		if (i == GRID_SIZE - 1) begin : g_tail
			assign shift_in = new_row;
		end else begin : g_body
			assign shift_in = rows[i+1];
		end
		lgge_row_cell #(.WIDTH(GRID_SIZE)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.sel      (ridx == IW'(i)),
			.col_sel  (col_sel),
			.shift_in (shift_in),
			.bits     (rows[i])
		);
	end

	// Advance sequencer: one row per cycle, the old head row kept as the next row's above.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			prev_q <= '0;
		end else if (busy_q) begin
			prev_q <= rows[0];
			step_q <= step_q + 1'b1;
			if (last_step) begin
				busy_q <= 1'b0;
				step_q <= '0;
			end
		end else if (accept && cmd.command == lgge_pkg::CMD_ADVANCE) begin
			busy_q <= 1'b1;
			step_q <= '0;
			prev_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept && cmd.command == lgge_pkg::CMD_READ) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd.command == lgge_pkg::CMD_READ) begin
			rsp_data_q <= in_grid ? rows[ridx][cidx] : 1'b0;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rsp_data_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !accept)
		else $error("request accepted during advance sweep");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.command == lgge_pkg::CMD_READ) |=> rsp.valid)
		else $error("read request gave no result");

	a_advance_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.command == lgge_pkg::CMD_ADVANCE) |=> (busy_q && step_q == '0))
		else $error("advance did not start sweep");

	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && last_step) |=> !busy_q)
		else $error("sweep overran the last row");

endmodule

[rtl/core/lgge_row_cell.sv]
// One row of the grid: a register that loads from its neighbor during a sweep
// and takes single-bit writes otherwise. Depends on lgge_pkg.
module lgge_row_cell #(
	parameter int WIDTH = lgge_pkg::GRID_SIZE_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lgge_pkg::cell_ctrl_t  ctrl,
	input  logic                  sel,
	input  logic [WIDTH-1:0]      col_sel,
	input  logic [WIDTH-1:0]      shift_in,
	output logic [WIDTH-1:0]      bits
);

	logic [WIDTH-1:0] bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
		end else if (ctrl.shift) begin
			bits_q <= shift_in;
		end else if (ctrl.wr && sel) begin
			for (int j = 0; j < WIDTH; j++) begin
				if (col_sel[j]) begin
					bits_q[j] <= ctrl.wr_val;
				end
			end
		end
	end

	assign bits = bits_q;

endmodule

[rtl/core/lgge_rule.sv]
// B3/S23 update of one row from the old rows above, at and below it.
// Columns beyond the edge count as dead. Depends on lgge_pkg.
module lgge_rule #(
	parameter int WIDTH = lgge_pkg::GRID_SIZE_DEFAULT
) (
	input  logic [WIDTH-1:0] above,
	input  logic [WIDTH-1:0] mid,
	input  logic [WIDTH-1:0] below,
	output logic [WIDTH-1:0] next
);

	localparam int CW = lgge_pkg::COUNT_W;

	logic [WIDTH+1:0] above_p, mid_p, below_p;

	assign above_p = {1'b0, above, 1'b0};
	assign mid_p   = {1'b0, mid, 1'b0};
	assign below_p = {1'b0, below, 1'b0};

	always_comb begin
		logic [CW-1:0] n;
		for (int j = 0; j < WIDTH; j++) begin
			n = CW'(above_p[j]) + CW'(above_p[j+1])
				+ CW'(above_p[j+2]) + CW'(mid_p[j])
				+ CW'(mid_p[j+2]) + CW'(below_p[j])
				+ CW'(below_p[j+1]) + CW'(below_p[j+2]);
			next[j] = (n == lgge_pkg::BIRTH_COUNT) || (mid[j] && n == lgge_pkg::SURVIVE_LOW);
		end
	end

endmodule

[bench/life_grid_generation_engine_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for life_grid_generation_engine: directed table, then random traffic.
// Depends on lgge_pkg, lgge_cmd_if, lgge_rsp_if and the engine RTL.
module life_grid_generation_engine_test;

	localparam int GRID_N       = lgge_pkg::GRID_SIZE_DEFAULT;
	localparam int RANDOM_ITEMS = 1600;
	localparam int HOLD_CYCLES  = 250;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 2 * GRID_N + 8;
	localparam int DIRECTED_ROWS = 25;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC
	} stall_mode_t;

	typedef struct packed {
		lgge_pkg::command_t                 command;
		logic [lgge_pkg::INDEX_W-1:0]       row;
		logic [lgge_pkg::INDEX_W-1:0]       column;
		logic                               cell_value;
		logic                               typed;
		logic                               typed_value;
	} stim_row_t;

	// typed rows carry a result that is obvious; the rest go through the grid model
	stim_row_t directed_table [DIRECTED_ROWS] = '{
		'{lgge_pkg::CMD_READ,    4'd0,  4'd0,  1'b0, 1'b1, 1'b0},
		'{lgge_pkg::CMD_READ,    4'd15, 4'd15, 1'b1, 1'b1, 1'b0},
		'{lgge_pkg::CMD_WRITE,   4'd0,  4'd0,  1'b1, 1'b0, 1'b0},
		'{lgge_pkg::CMD_READ,    4'd0,  4'd0,  1'b0, 1'b1, 1'b1},
		'{lgge_pkg::CMD_WRITE,   4'd15, 4'd15, 1'b1, 1'b0, 1'b0},
		'{lgge_pkg::CMD_READ,    4'd15, 4'd15, 1'b0, 1'b1, 1'b1},
		'{lgge_pkg::CMD_UNUSED,  4'd15, 4'd15, 1'b0, 1'b0, 1'b0},
		'{lgge_pkg::CMD_READ,    4'd15, 4'd15, 1'b0, 1'b1, 1'b1},
		'{lgge_pkg::CMD_WRITE,   4'd0,  4'd15, 1'b1, 1'b0, 1'b0},
		'{lgge_pkg::CMD_WRITE,   4'd15, 4'd0,  1'b1, 1'b0, 1'b0},
		'{lgge_pkg::CMD_ADVANCE, 4'd9,  4'd6,  1'b1, 1'b0, 1'b0},
		'{lgge_pkg::CMD_READ,    4'd0,  4'd15, 1'b0, 1'b1, 1'b0},
		'{lgge_pkg::CMD_WRITE,   4'd7,  4'd6,  1'b1, 1'b0, 1'b0},
		'{lgge_pkg::CMD_WRITE,   4'd7,  4'd7,  1'b1, 1'b0, 1'b0},
		'{lgge_pkg::CMD_WRITE,   4'd7,  4'd8,  1'b1, 1'b0, 1'b0},
		'{lgge_pkg::CMD_ADVANCE, 4'd0,  4'd0,  1'b0, 1'b0, 1'b0},
		'{lgge_pkg::CMD_READ,    4'd6,  4'd7,  1'b0, 1'b0, 1'b0},
		'{lgge_pkg::CMD_READ,    4'd7,  4'd6,  1'b0, 1'b0, 1'b0},
		'{lgge_pkg::CMD_READ,    4'd8,  4'd7,  1'b0, 1'b0, 1'b0},
		'{lgge_pkg::CMD_WRITE,   4'd0,  4'd0,  1'b1, 1'b0, 1'b0},
		'{lgge_pkg::CMD_WRITE,   4'd0,  4'd1,  1'b1, 1'b0, 1'b0},
		'{lgge_pkg::CMD_WRITE,   4'd1,  4'd0,  1'b1, 1'b0, 1'b0},
		'{lgge_pkg::CMD_ADVANCE, 4'd15, 4'd15, 1'b1, 1'b0, 1'b0},
		'{lgge_pkg::CMD_READ,    4'd1,  4'd1,  1'b0, 1'b0, 1'b0},
		'{lgge_pkg::CMD_READ,    4'd0,  4'd0,  1'b1, 1'b0, 1'b0}
	};

	logic clk;
	logic arst_n;

	lgge_cmd_if cmd_ch ();
	lgge_rsp_if rsp_ch ();

	life_grid_generation_engine u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	logic life_grid [GRID_N][GRID_N] = '{default: '{default: 1'b0}};
	logic expected_reads [$];
	int   mismatch_count = 0;
	int   idle_cycles = 0;
	int   burst_left = 0;
	bit   hold_request = 1'b0;
	bit   hold_done = 1'b0;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// One B3/S23 generation; cells past the edge count as dead.
	task automatic advance_grid();
		logic next_cells [GRID_N][GRID_N];
		int live;
		int nr;
		int nc;
		for (int r = 0; r < GRID_N; r++) begin
			for (int c = 0; c < GRID_N; c++) begin
				live = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						nr = r + dr;
						nc = c + dc;
						if ((dr != 0 || dc != 0) && nr >= 0 && nr < GRID_N
						    && nc >= 0 && nc < GRID_N && life_grid[nr][nc])
							live++;
					end
				end
				if (life_grid[r][c])
					next_cells[r][c] = (live == lgge_pkg::SURVIVE_LOW)
					                   || (live == lgge_pkg::BIRTH_COUNT);
				else
					next_cells[r][c] = (live == lgge_pkg::BIRTH_COUNT);
			end
		end
		life_grid = next_cells;
	endtask

	task automatic predict_request(input lgge_pkg::command_t command,
	                               input logic [lgge_pkg::INDEX_W-1:0] row,
	                               input logic [lgge_pkg::INDEX_W-1:0] column,
	                               input logic cell_value,
	                               output bit has_read, output logic read_value);
		bit in_grid;
		in_grid = (int'(row) < GRID_N) && (int'(column) < GRID_N);
		has_read = 1'b0;
		read_value = 1'b0;
		case (command)
			lgge_pkg::CMD_WRITE: begin
				if (in_grid)
					life_grid[row][column] = cell_value;
			end
			lgge_pkg::CMD_READ: begin
				has_read = 1'b1;
				read_value = in_grid ? life_grid[row][column] : 1'b0;
			end
			lgge_pkg::CMD_ADVANCE: begin
				advance_grid();
			end
			default: begin
			end
		endcase
	endtask

	// Offer one request, hold it until taken, then update the grid model.
	task automatic offer_request(input lgge_pkg::command_t command,
	                             input logic [lgge_pkg::INDEX_W-1:0] row,
	                             input logic [lgge_pkg::INDEX_W-1:0] column,
	                             input logic cell_value,
	                             input logic typed, input logic typed_value);
		bit   has_read;
		logic read_value;
		cmd_ch.valid      <= 1'b1;
		cmd_ch.command    <= command;
		cmd_ch.row        <= row;
		cmd_ch.column     <= column;
		cmd_ch.cell_value <= cell_value;
		@(posedge clk);
		while (!(cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1))
			@(posedge clk);
		predict_request(command, row, column, cell_value, has_read, read_value);
		if (has_read)
			expected_reads.push_back(typed ? typed_value : read_value);
	endtask

	// Bursts of back-to-back requests with random gaps; no gaps while the receiver holds off.
	task automatic pace_sender();
		int gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 9) < 3 || (hold_request && !hold_done))
				gap = 0;
			else
				gap = $urandom_range(1, 12);
			if (gap > 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		stall_mode_t mode;
		int mode_left;
		int phase;
		rsp_ch.ready = 1'b0;
		mode = STALL_NONE;
		mode_left = 0;
		phase = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request && !hold_done) begin
				// long hold-off: let the result register fill and back up the request side
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = stall_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(10, 120);
				end
				mode_left--;
				phase++;
				case (mode)
					STALL_NONE:     rsp_ch.ready <= 1'b1;
					STALL_RANDOM:   rsp_ch.ready <= 1'($urandom_range(0, 1));
					default:        rsp_ch.ready <= (phase % 4 != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		logic want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (expected_reads.size() == 0) begin
				$error("read_value %0b returned with no read outstanding", rsp_ch.read_value);
				mismatch_count++;
			end else begin
				want = expected_reads.pop_front();
				if (rsp_ch.read_value !== want) begin
					$error("read_value mismatch: expected %0b, actual %0b",
					       want, rsp_ch.read_value);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1)
		    || (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		lgge_pkg::command_t                 command;
		logic [lgge_pkg::INDEX_W-1:0]       row;
		logic [lgge_pkg::INDEX_W-1:0]       column;
		logic [lgge_pkg::INDEX_W-1:0]       base_row;
		logic [lgge_pkg::INDEX_W-1:0]       base_column;
		logic                               cell_value;
		int                                 pick;
		int                                 counted;
		arst_n            = 1'b0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.command    = lgge_pkg::CMD_WRITE;
		cmd_ch.row        = '0;
		cmd_ch.column     = '0;
		cmd_ch.cell_value = 1'b0;
		base_row = 4'd6;
		base_column = 4'd6;
		counted = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			offer_request(directed_table[i].command, directed_table[i].row,
			              directed_table[i].column, directed_table[i].cell_value,
			              directed_table[i].typed, directed_table[i].typed_value);
			pace_sender();
		end

		while (counted < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			// keep most accesses in a small window so patterns form and evolve
			if ($urandom_range(0, 9) < 7) begin
				row    = 4'(base_row + $urandom_range(0, 3));
				column = 4'(base_column + $urandom_range(0, 3));
			end else begin
				row    = 4'($urandom_range(0, 15));
				column = 4'($urandom_range(0, 15));
			end
			cell_value = ($urandom_range(0, 99) < 65);
			if (pick < 45)
				command = lgge_pkg::CMD_WRITE;
			else if (pick < 80)
				command = lgge_pkg::CMD_READ;
			else if (pick < 92)
				command = lgge_pkg::CMD_ADVANCE;
			else
				command = lgge_pkg::CMD_UNUSED;
			if (counted == 300)
				hold_request = 1'b1;
			offer_request(command, row, column, cell_value, 1'b0, 1'b0);
			if (command != lgge_pkg::CMD_UNUSED)
				counted++;
			if (command == lgge_pkg::CMD_ADVANCE && $urandom_range(0, 3) == 0) begin
				base_row    = 4'($urandom_range(0, 15));
				base_column = 4'($urandom_range(0, 15));
			end
			pace_sender();
		end

		cmd_ch.valid <= 1'b0;
		while (expected_reads.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/lgge_pkg.sv
rtl/core/lgge_cmd_if.sv
rtl/core/lgge_rsp_if.sv
rtl/core/lgge_row_cell.sv
rtl/core/lgge_rule.sv
rtl/core/life_grid_generation_engine.sv
bench/life_grid_generation_engine_test.sv
